// File: hw/rtl/soft_clip_site_counter_defines.svh
// Assertion helpers for the soft-clip site counter.
// They expect clk and arst_n in the scope where they are used.
`ifndef SOFT_CLIP_SITE_COUNTER_DEFINES_SVH
`define SOFT_CLIP_SITE_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SCC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SCC_ASSERT(lbl, prop, msg)
`define SCC_NEVER(lbl, expr, msg)
`endif
`endif

// File: hw/rtl/scc_pkg.sv
`default_nettype none
package scc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int MAX_CLIPS   = 2;

	localparam int TBL_AW  = $clog2(TABLE_DEPTH);
	localparam int TBL_CW  = TBL_AW + 1;
	localparam int CLIP_IW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
	localparam int CLIP_CW = $clog2(MAX_CLIPS + 1);

	localparam logic [TBL_CW-1:0]  TBL_END  = TBL_CW'(TABLE_DEPTH);
	localparam logic [TBL_AW-1:0]  TBL_LAST = TBL_AW'(TABLE_DEPTH - 1);
	localparam logic [CLIP_CW-1:0] CLIP_END = CLIP_CW'(MAX_CLIPS);

	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_CIGAR  = 2'd1,
		MODE_QUAL   = 2'd2,
		MODE_FLUSH  = 2'd3
	} mode_t;

	localparam logic [3:0] CIG_MATCH = 4'd0;
	localparam logic [3:0] CIG_INS   = 4'd1;
	localparam logic [3:0] CIG_DEL   = 4'd2;
	localparam logic [3:0] CIG_SKIP  = 4'd3;
	localparam logic [3:0] CIG_SOFT  = 4'd4;
	localparam logic [3:0] CIG_EQ    = 4'd7;
	localparam logic [3:0] CIG_DIFF  = 4'd8;

	localparam logic [2:0] CFG_FLAG_MASK  = 3'd0;
	localparam logic [2:0] CFG_MIN_MAPQ   = 3'd1;
	localparam logic [2:0] CFG_MAX_REF    = 3'd2;
	localparam logic [2:0] CFG_MIN_CLIP   = 3'd3;
	localparam logic [2:0] CFG_MIN_AVGQ   = 3'd4;
	localparam logic [2:0] CFG_REPORT_MIN = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLIP_SEL,
		ST_APPLY,
		ST_DECIDE,
		ST_FLUSH,
		ST_FLUSH_END,
		ST_HDR_END
	} state_t;

	typedef struct packed {
		logic              take_cigar;
		logic              take_qual;
		logic              latch_hdr;
		logic              scan_init;
		logic              rd_en;
		logic [TBL_AW-1:0] rd_addr;
		logic              apply_cmp;
		logic [CLIP_IW-1:0] clip_sel;
		logic              finish;
		logic              flush_cmp;
		logic              flush_end;
		logic              hdr_end;
	} scc_cmd_t;

	typedef struct packed {
		logic                 read_kept;
		logic [MAX_CLIPS-1:0] pending;
		logic                 hit;
		logic                 s1_last;
		logic                 hdr_pass;
		logic                 ref_change;
	} scc_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/scc_dp.sv
`default_nettype none
module scc_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scc_pkg::scc_cmd_t   cmd,
	output scc_pkg::scc_stat_t       stat,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic [15:0]         ref_id,
	input  wire logic [30:0]         read_start,
	input  wire logic [15:0]         read_flags,
	input  wire logic [7:0]          map_quality,
	input  wire logic [3:0]          cigar_code,
	input  wire logic [27:0]         op_length,
	input  wire logic [7:0]          base_quality,
	output logic                     result_valid,
	output logic [14:0]              site_ref_id,
	output logic [30:0]              site_position,
	output logic [31:0]              site_count,
	output logic                     last_of_run
);
	import scc_pkg::*;

	// configuration
	logic [15:0] flag_mask_q;
	logic [7:0]  min_mapq_q;
	logic [14:0] max_ref_q;
	logic [27:0] min_clip_q;
	logic [7:0]  min_avgq_q;
	logic [31:0] report_min_q;

	// read state
	logic [15:0] cur_ref_q;
	logic        kept_q;
	logic [31:0] ref_cur_q;
	logic [27:0] qry_cur_q;
	logic [31:0] qidx_q;
	logic [15:0] h_rid_q;
	logic [30:0] h_start_q;
	logic [15:0] h_flags_q;
	logic [7:0]  h_mapq_q;

	logic [30:0] clip_site_q [MAX_CLIPS];
	logic [27:0] clip_start_q [MAX_CLIPS];
	logic [27:0] clip_len_q [MAX_CLIPS];
	logic [35:0] clip_sum_q [MAX_CLIPS];
	logic [MAX_CLIPS-1:0] pend_q;

	// site table
	logic [30:0] pos_mem [TABLE_DEPTH];
	logic [31:0] cnt_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	logic              act_s1;
	logic              vld_s1;
	logic [TBL_AW-1:0] idx_s1;
	logic [30:0]       pos_s1;
	logic [31:0]       cnt_s1;

	logic              free_v_q;
	logic [TBL_AW-1:0] free_idx_q;
	logic [36:0]       prod_q;

	logic              held_v_q;
	logic [30:0]       held_pos_q;
	logic [31:0]       held_cnt_q;

	logic              res_v_q;
	logic [14:0]       res_ref_q;
	logic [30:0]       res_pos_q;
	logic [31:0]       res_cnt_q;
	logic              res_last_q;

	logic [30:0]       sel_site;
	logic [27:0]       sel_len;
	logic [35:0]       sel_sum;
	logic              hit;
	logic              s1_last;
	logic              eligible;
	logic              ins;
	logic              mem_we;
	logic [TBL_AW-1:0] mem_waddr;
	logic [30:0]       mem_wpos;
	logic [31:0]       mem_wcnt;
	logic [31:0]       cnt_inc;
	logic              cap_v;
	logic [CLIP_IW-1:0] cap_k;
	logic [MAX_CLIPS-1:0] in_rng;
	logic              rid_ok;
	logic              fl_qual;

	assign sel_site = clip_site_q[cmd.clip_sel];
	assign sel_len  = clip_len_q[cmd.clip_sel];
	assign sel_sum  = clip_sum_q[cmd.clip_sel];
	assign hit      = act_s1 && vld_s1 && (pos_s1 == sel_site);
	assign s1_last  = act_s1 && (idx_s1 == TBL_LAST);
	assign cnt_inc  = (cnt_s1 == 32'hFFFF_FFFF) ? cnt_s1 : cnt_s1 + 32'd1;
	// floor(sum/len) > m  <=>  sum >= (m+1)*len
	assign eligible = (sel_len != 28'd0) && (sel_len >= min_clip_q) &&
		({1'b0, sel_sum} >= prod_q);
	assign ins = cmd.apply_cmp && act_s1 && !hit && s1_last && eligible &&
		(free_v_q || !vld_s1);

	always_comb begin
		mem_we    = (cmd.apply_cmp && hit) || ins;
		mem_waddr = hit ? idx_s1 : (free_v_q ? free_idx_q : idx_s1);
		mem_wpos  = hit ? pos_s1 : sel_site;
		mem_wcnt  = hit ? cnt_inc : 32'd1;
	end

	always_comb begin
		cap_v = 1'b0;
		cap_k = '0;
		for (int k = MAX_CLIPS - 1; k >= 0; k--) begin
			if (!pend_q[k]) begin
				cap_v = 1'b1;
				cap_k = CLIP_IW'(k);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < MAX_CLIPS; k++) begin
			in_rng[k] = pend_q[k] && (qidx_q >= {4'd0, clip_start_q[k]}) &&
				((qidx_q - {4'd0, clip_start_q[k]}) < {4'd0, clip_len_q[k]});
		end
	end

	assign rid_ok  = !h_rid_q[15] && (h_rid_q[14:0] <= max_ref_q);
	assign fl_qual = vld_s1 && (cnt_s1 > report_min_q);

	always_comb begin
		stat.read_kept  = kept_q;
		stat.pending    = pend_q;
		stat.hit        = hit;
		stat.s1_last    = s1_last;
		stat.hdr_pass   = ((h_flags_q & flag_mask_q) == 16'd0) && (h_mapq_q >= min_mapq_q);
		stat.ref_change = (h_rid_q != cur_ref_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_mask_q  <= 16'd1796;
			min_mapq_q   <= 8'd20;
			max_ref_q    <= 15'd23;
			min_clip_q   <= 28'd10;
			min_avgq_q   <= 8'd20;
			report_min_q <= 32'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLAG_MASK:  flag_mask_q  <= cfg_data[15:0];
				CFG_MIN_MAPQ:   min_mapq_q   <= cfg_data[7:0];
				CFG_MAX_REF:    max_ref_q    <= cfg_data[14:0];
				CFG_MIN_CLIP:   min_clip_q   <= cfg_data[27:0];
				CFG_MIN_AVGQ:   min_avgq_q   <= cfg_data[7:0];
				CFG_REPORT_MIN: report_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// read walk: cursors, clip capture, quality sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ref_q <= 16'd0;
			kept_q    <= 1'b0;
			ref_cur_q <= 32'd0;
			qry_cur_q <= 28'd0;
			qidx_q    <= 32'd0;
			pend_q    <= '0;
			for (int k = 0; k < MAX_CLIPS; k++) begin
				clip_site_q[k]  <= '0;
				clip_start_q[k] <= '0;
				clip_len_q[k]   <= '0;
				clip_sum_q[k]   <= '0;
			end
		end else begin
			if (cmd.take_cigar && kept_q) begin
				if (cigar_code == CIG_MATCH || cigar_code == CIG_EQ ||
				    cigar_code == CIG_DIFF) begin
					ref_cur_q <= ref_cur_q + {4'd0, op_length};
					qry_cur_q <= qry_cur_q + op_length;
				end else if (cigar_code == CIG_DEL || cigar_code == CIG_SKIP) begin
					ref_cur_q <= ref_cur_q + {4'd0, op_length};
				end else if (cigar_code == CIG_INS) begin
					qry_cur_q <= qry_cur_q + op_length;
				end else if (cigar_code == CIG_SOFT) begin
					if (cap_v) begin
						pend_q[cap_k]       <= 1'b1;
						clip_site_q[cap_k]  <= ref_cur_q[30:0];
						clip_start_q[cap_k] <= qry_cur_q;
						clip_len_q[cap_k]   <= op_length;
						clip_sum_q[cap_k]   <= '0;
					end
					qry_cur_q <= qry_cur_q + op_length;
				end
			end
			if (cmd.take_qual && kept_q) begin
				for (int k = 0; k < MAX_CLIPS; k++) begin
					if (in_rng[k])
						clip_sum_q[k] <= clip_sum_q[k] + {28'd0, base_quality};
				end
				if (qidx_q != 32'hFFFF_FFFF)
					qidx_q <= qidx_q + 32'd1;
			end
			if (cmd.finish) begin
				kept_q <= 1'b0;
				pend_q <= '0;
				for (int k = 0; k < MAX_CLIPS; k++) begin
					clip_site_q[k]  <= '0;
					clip_start_q[k] <= '0;
					clip_len_q[k]   <= '0;
					clip_sum_q[k]   <= '0;
				end
			end
			if (cmd.hdr_end) begin
				cur_ref_q <= h_rid_q;
				if (rid_ok) begin
					kept_q    <= 1'b1;
					ref_cur_q <= {1'b0, h_start_q};
					qry_cur_q <= 28'd0;
					qidx_q    <= 32'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_hdr) begin
			h_rid_q   <= ref_id;
			h_start_q <= read_start;
			h_flags_q <= read_flags;
			h_mapq_q  <= map_quality;
		end
		prod_q <= ({1'b0, min_avgq_q} + 9'd1) * sel_len;
	end

	// table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pos_mem[mem_waddr] <= mem_wpos;
			cnt_mem[mem_waddr] <= mem_wcnt;
		end
		pos_s1 <= pos_mem[cmd.rd_addr];
		cnt_s1 <= cnt_mem[cmd.rd_addr];
		vld_s1 <= valid_q[cmd.rd_addr];
		idx_s1 <= cmd.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1     <= 1'b0;
			valid_q    <= '0;
			free_v_q   <= 1'b0;
			free_idx_q <= '0;
			held_v_q   <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			act_s1  <= cmd.rd_en;
			// one site is held back so the final beat can carry last_of_run
			res_v_q <= held_v_q && ((cmd.flush_cmp && act_s1 && fl_qual) || cmd.flush_end);
			if (cmd.scan_init)
				free_v_q <= 1'b0;
			else if (cmd.apply_cmp && act_s1 && !vld_s1 && !free_v_q) begin
				free_v_q   <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (ins)
				valid_q[mem_waddr] <= 1'b1;
			if (cmd.flush_cmp && act_s1 && fl_qual)
				held_v_q <= 1'b1;
			if (cmd.flush_end) begin
				valid_q  <= '0;
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush_cmp && act_s1 && fl_qual) begin
			held_pos_q <= pos_s1;
			held_cnt_q <= cnt_s1;
			res_ref_q  <= cur_ref_q[14:0];
			res_pos_q  <= held_pos_q;
			res_cnt_q  <= held_cnt_q;
			res_last_q <= 1'b0;
		end else if (cmd.flush_end) begin
			res_ref_q  <= cur_ref_q[14:0];
			res_pos_q  <= held_pos_q;
			res_cnt_q  <= held_cnt_q;
			res_last_q <= 1'b1;
		end
	end

	assign result_valid  = res_v_q;
	assign site_ref_id   = res_ref_q;
	assign site_position = res_pos_q;
	assign site_count    = res_cnt_q;
	assign last_of_run   = res_last_q;

endmodule
`default_nettype wire

// File: hw/rtl/scc_ctrl.sv
`default_nettype none
`include "soft_clip_site_counter_defines.svh"
module scc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         mode,
	output logic                    busy,
	output scc_pkg::scc_cmd_t       cmd,
	input  wire scc_pkg::scc_stat_t stat
);
	import scc_pkg::*;

	state_t             state_q, state_d;
	logic [CLIP_CW-1:0] k_q, k_d;
	logic [TBL_CW-1:0]  cnt_q, cnt_d;
	logic               hdr_q, hdr_d;
	logic [CLIP_IW-1:0] k_idx;

	assign k_idx = k_q[CLIP_IW-1:0];
	assign busy  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
			hdr_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			cnt_q   <= cnt_d;
			hdr_q   <= hdr_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		cnt_d    = cnt_q;
		hdr_d    = hdr_q;
		cmd      = '0;
		cmd.rd_addr  = cnt_q[TBL_AW-1:0];
		cmd.clip_sel = k_idx;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (mode_t'(mode))
						MODE_HEADER, MODE_FLUSH: begin
							cmd.latch_hdr = (mode_t'(mode) == MODE_HEADER);
							hdr_d   = (mode_t'(mode) == MODE_HEADER);
							k_d     = '0;
							state_d = ST_CLIP_SEL;
						end
						MODE_CIGAR: cmd.take_cigar = 1'b1;
						MODE_QUAL:  cmd.take_qual  = 1'b1;
						default: ;
					endcase
				end
			end
			ST_CLIP_SEL: begin
				if (k_q == CLIP_END) begin
					cmd.finish = 1'b1;
					state_d    = ST_DECIDE;
				end else if (stat.read_kept && stat.pending[k_idx]) begin
					cmd.scan_init = 1'b1;
					cnt_d   = '0;
					state_d = ST_APPLY;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_APPLY: begin
				cmd.apply_cmp = 1'b1;
				cmd.rd_en     = (cnt_q < TBL_END);
				if (cmd.rd_en)
					cnt_d = cnt_q + 1'b1;
				if (stat.hit || stat.s1_last) begin
					k_d     = k_q + 1'b1;
					state_d = ST_CLIP_SEL;
				end
			end
			ST_DECIDE: begin
				cnt_d = '0;
				priority if (!hdr_q)
					state_d = ST_FLUSH;
				else if (!stat.hdr_pass)
					state_d = ST_IDLE;
				else if (stat.ref_change)
					state_d = ST_FLUSH;
				else
					state_d = ST_HDR_END;
			end
			ST_FLUSH: begin
				cmd.flush_cmp = 1'b1;
				cmd.rd_en     = (cnt_q < TBL_END);
				if (cmd.rd_en)
					cnt_d = cnt_q + 1'b1;
				if (stat.s1_last)
					state_d = ST_FLUSH_END;
			end
			ST_FLUSH_END: begin
				cmd.flush_end = 1'b1;
				state_d = hdr_q ? ST_HDR_END : ST_IDLE;
			end
			ST_HDR_END: begin
				cmd.hdr_end = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SCC_NEVER(a_cnt_range, cnt_q > TBL_END, "scan counter ran past the table")
	`SCC_NEVER(a_clip_range, k_q > CLIP_END, "clip index ran past the clip slots")
	`SCC_ASSERT(a_flush_cause, (state_q == ST_DECIDE && state_d == ST_FLUSH) |-> (!hdr_q || (stat.hdr_pass && stat.ref_change)), "flush without cause")
	`SCC_ASSERT(a_apply_kept, (state_q == ST_APPLY) |-> stat.read_kept, "clip applied for a dropped read")

endmodule
`default_nettype wire

// File: hw/rtl/soft_clip_site_counter.sv
`default_nettype none
// Soft-clip site counter. Items are taken when start is high and busy low.
// CIGAR and quality beats leave busy low. A header or an end-of-input beat
// holds busy while the read before it is finished: each pending clip scans
// the 64-entry site table one entry a cycle, stopping early on a hit; a flush
// (end of input, or a passing header that changes the reference) then scans
// the table again and emits qualifying sites. Results come at most one per
// cycle on result_valid and cannot be stalled by the receiver; the final site
// of a flush carries last_of_run. Write configuration only while busy is low.
module soft_clip_site_counter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         mode,
	input  wire logic signed [15:0] ref_id,
	input  wire logic [30:0]        read_start,
	input  wire logic [15:0]        read_flags,
	input  wire logic [7:0]         map_quality,
	input  wire logic [3:0]         cigar_code,
	input  wire logic [27:0]        op_length,
	input  wire logic [7:0]         base_quality,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic                    result_valid,
	output logic [14:0]             site_ref_id,
	output logic [30:0]             site_position,
	output logic [31:0]             site_count,
	output logic                    last_of_run
);
	import scc_pkg::*;

	scc_cmd_t  cmd;
	scc_stat_t stat;

	scc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	scc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.ref_id        ($unsigned(ref_id)),
		.read_start    (read_start),
		.read_flags    (read_flags),
		.map_quality   (map_quality),
		.cigar_code    (cigar_code),
		.op_length     (op_length),
		.base_quality  (base_quality),
		.result_valid  (result_valid),
		.site_ref_id   (site_ref_id),
		.site_position (site_position),
		.site_count    (site_count),
		.last_of_run   (last_of_run)
	);

endmodule
`default_nettype wire

// File: bench/scc_checker.sv
`timescale 1ns / 100ps
module scc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [15:0] ref_id,
	input  logic [30:0]        read_start,
	input  logic [15:0]        read_flags,
	input  logic [7:0]         map_quality,
	input  logic [3:0]         cigar_code,
	input  logic [27:0]        op_length,
	input  logic [7:0]         base_quality,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               result_valid,
	input  logic [14:0]        site_ref_id,
	input  logic [30:0]        site_position,
	input  logic [31:0]        site_count,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 sites_pending,
	output int                 sites_seen
);
	import scc_pkg::*;

	typedef struct packed {
		logic [14:0] rid;
		logic [30:0] pos;
		logic [31:0] cnt;
		logic        last;
	} site_rpt_t;

	site_rpt_t site_q[$];

	bit [15:0] r_flag_mask;
	bit [7:0]  r_min_mapq;
	bit [14:0] r_max_ref;
	bit [27:0] r_min_clip;
	bit [7:0]  r_min_avgq;
	bit [31:0] r_report_min;

	bit [30:0] tbl_pos  [TABLE_DEPTH];
	bit [31:0] tbl_cnt  [TABLE_DEPTH];
	bit        tbl_used [TABLE_DEPTH];
	bit [15:0] cur_ref;
	bit        kept;
	bit [31:0] ref_cur;
	bit [27:0] qry_cur;
	bit [31:0] qual_idx;
	bit [30:0] clp_site [MAX_CLIPS];
	bit [27:0] clp_start[MAX_CLIPS];
	bit [27:0] clp_len  [MAX_CLIPS];
	bit [63:0] clp_qsum [MAX_CLIPS];
	bit        clp_open [MAX_CLIPS];

	assign sites_pending = site_q.size();

	function automatic void count_clip(int k);
		int free_slot;
		free_slot = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (tbl_used[i] && tbl_pos[i] == clp_site[k]) begin
				if (tbl_cnt[i] != 32'hffff_ffff)
					tbl_cnt[i]++;
				return;
			end
			if (!tbl_used[i] && free_slot < 0)
				free_slot = i;
		end
		if (clp_len[k] == 0 || clp_len[k] < r_min_clip)
			return;
		if (clp_qsum[k] / clp_len[k] <= r_min_avgq)
			return;
		if (free_slot < 0)
			return;
		tbl_used[free_slot] = 1'b1;
		tbl_pos[free_slot]  = clp_site[k];
		tbl_cnt[free_slot]  = 1;
	endfunction

	function automatic void close_read();
		if (kept)
			for (int k = 0; k < MAX_CLIPS; k++)
				if (clp_open[k])
					count_clip(k);
		for (int k = 0; k < MAX_CLIPS; k++) begin
			clp_open[k]  = 1'b0;
			clp_site[k]  = '0;
			clp_start[k] = '0;
			clp_len[k]   = '0;
			clp_qsum[k]  = '0;
		end
		kept = 1'b0;
	endfunction

	function automatic void report_sites();
		int n;
		n = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (tbl_used[i] && tbl_cnt[i] > r_report_min) begin
				site_q.push_back('{cur_ref[14:0], tbl_pos[i], tbl_cnt[i], 1'b0});
				n++;
			end
			tbl_used[i] = 1'b0;
		end
		if (n > 0)
			site_q[site_q.size() - 1].last = 1'b1;
	endfunction

	function automatic void predict_beat();
		bit [15:0] rid;
		rid = ref_id;
		case (mode_t'(mode))
		MODE_HEADER: begin
			close_read();
			if ((read_flags & r_flag_mask) != 0 || map_quality < r_min_mapq)
				return;
			if (rid != cur_ref) begin
				report_sites();
				cur_ref = rid;
			end
			if (!rid[15] && rid[14:0] <= r_max_ref) begin
				kept     = 1'b1;
				ref_cur  = {1'b0, read_start};
				qry_cur  = '0;
				qual_idx = '0;
			end
		end
		MODE_FLUSH: begin
			close_read();
			report_sites();
		end
		MODE_CIGAR: begin
			if (!kept)
				return;
			case (cigar_code)
			CIG_MATCH, CIG_EQ, CIG_DIFF: begin
				ref_cur += op_length;
				qry_cur += op_length;
			end
			CIG_DEL, CIG_SKIP: ref_cur += op_length;
			CIG_INS: qry_cur += op_length;
			CIG_SOFT: begin
				for (int k = 0; k < MAX_CLIPS; k++)
					if (!clp_open[k]) begin
						clp_open[k]  = 1'b1;
						clp_site[k]  = ref_cur[30:0];
						clp_start[k] = qry_cur;
						clp_len[k]   = op_length;
						clp_qsum[k]  = '0;
						break;
					end
				qry_cur += op_length;
			end
			default: ;
			endcase
		end
		default: begin
			if (!kept)
				return;
			for (int k = 0; k < MAX_CLIPS; k++)
				if (clp_open[k] && qual_idx >= clp_start[k] &&
						qual_idx - clp_start[k] < clp_len[k])
					clp_qsum[k] += base_quality;
			if (qual_idx != 32'hffff_ffff)
				qual_idx++;
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		site_rpt_t want;
		if (!arst_n) begin
			r_flag_mask  = 16'd1796;
			r_min_mapq   = 8'd20;
			r_max_ref    = 15'd23;
			r_min_clip   = 28'd10;
			r_min_avgq   = 8'd20;
			r_report_min = 32'd5;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				tbl_used[i] = 1'b0;
				tbl_pos[i]  = '0;
				tbl_cnt[i]  = '0;
			end
			cur_ref  = '0;
			ref_cur  = '0;
			qry_cur  = '0;
			qual_idx = '0;
			kept     = 1'b0;
			close_read();
			site_q.delete();
			fail_count = 0;
			sites_seen = 0;
		end else begin
			if (result_valid) begin
				sites_seen++;
				if (site_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected site beat ref %0d pos %0d %s %0d last %0b",
							$realtime, site_ref_id, site_position, "count",
							site_count, last_of_run);
				end else begin
					want = site_q.pop_front();
					if (want.rid != site_ref_id || want.pos != site_position ||
							want.cnt != site_count || want.last != last_of_run) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: site mismatch exp ref %0d pos %0d count %0d last %0b,",
								$realtime, want.rid, want.pos, want.cnt, want.last);
							$display("    got ref %0d pos %0d count %0d last %0b",
								site_ref_id, site_position, site_count, last_of_run);
						end
					end
				end
			end
			if (cfg_we)
				case (cfg_index)
				CFG_FLAG_MASK:  r_flag_mask  = cfg_data[15:0];
				CFG_MIN_MAPQ:   r_min_mapq   = cfg_data[7:0];
				CFG_MAX_REF:    r_max_ref    = cfg_data[14:0];
				CFG_MIN_CLIP:   r_min_clip   = cfg_data[27:0];
				CFG_MIN_AVGQ:   r_min_avgq   = cfg_data[7:0];
				CFG_REPORT_MIN: r_report_min = cfg_data;
				default: ;
				endcase
			if (start && !busy)
				predict_beat();
		end
	end

endmodule

// File: bench/tb_soft_clip_site_counter.sv
`timescale 1ns / 100ps
module tb_soft_clip_site_counter;
	import scc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         mode = '0;
	logic signed [15:0] ref_id = '0;
	logic [30:0]        read_start = '0;
	logic [15:0]        read_flags = '0;
	logic [7:0]         map_quality = '0;
	logic [3:0]         cigar_code = '0;
	logic [27:0]        op_length = '0;
	logic [7:0]         base_quality = '0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               result_valid;
	logic [14:0]        site_ref_id;
	logic [30:0]        site_position;
	logic [31:0]        site_count;
	logic               last_of_run;

	int fail_count, sites_pending, sites_seen;
	int idle_pct;
	int beats_sent;
	int reads_sent;

	soft_clip_site_counter u_dut (.*);

	scc_checker u_chk (.*);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("timeout with %0d site beats outstanding", sites_pending);
		$display("** soft_clip_site_counter: FAILED **");
		$finish;
	end

	task automatic beat(input logic [1:0] m, input logic [15:0] rid, input logic [30:0] rs,
			input logic [15:0] fl, input logic [7:0] mq, input logic [3:0] cc,
			input logic [27:0] ol, input logic [7:0] bq);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start        <= 1'b1;
		mode         <= m;
		ref_id       <= rid;
		read_start   <= rs;
		read_flags   <= fl;
		map_quality  <= mq;
		cigar_code   <= cc;
		op_length    <= ol;
		base_quality <= bq;
		@(posedge clk);
		while (busy) @(posedge clk);
		beats_sent++;
	endtask

	task automatic header(input logic [15:0] rid, input logic [30:0] rs,
			input logic [15:0] fl, input logic [7:0] mq);
		beat(MODE_HEADER, rid, rs, fl, mq, 4'($urandom), 28'($urandom), 8'($urandom));
		reads_sent++;
	endtask

	task automatic cigar(input logic [3:0] cc, input logic [27:0] ol);
		beat(MODE_CIGAR, 16'($urandom), 31'($urandom), 16'($urandom), 8'($urandom),
			cc, ol, 8'($urandom));
	endtask

	task automatic qual(input logic [7:0] bq);
		beat(MODE_QUAL, 16'($urandom), 31'($urandom), 16'($urandom), 8'($urandom),
			4'($urandom), 28'($urandom), bq);
	endtask

	task automatic flush_all();
		beat(MODE_FLUSH, 16'($urandom), 31'($urandom), 16'($urandom), 8'($urandom),
			4'($urandom), 28'($urandom), 8'($urandom));
	endtask

	// drain: busy low, every expected site out, then room for a clip pass
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || sites_pending != 0) @(posedge clk);
		repeat (3 * TABLE_DEPTH + 20) @(posedge clk);
	endtask

	task automatic set_regs(input logic [31:0] fm, mq, mr, mc, ma, rm);
		logic [31:0] vals[6];
		vals = '{fm, mq, mr, mc, ma, rm};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic rand_read();
		logic [15:0] rid;
		logic [30:0] rs;
		logic [3:0]  cc;
		logic [27:0] ol;
		int          qlen, nops, sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)      rid = 16'($urandom_range(0, 2));
		else if (sel == 7) rid = 16'hffff;
		else if (sel == 8) rid = 16'($urandom);
		else              rid = 16'($urandom_range(0, 40));
		sel = $urandom_range(0, 19);
		if (sel == 0)      rs = 31'($urandom);
		else if (sel == 1) rs = 31'h7fff_fff0 + 31'($urandom_range(0, 15));
		else               rs = 31'(1000 + 16 * $urandom_range(0, 5));
		header(rid, rs, ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h0,
			($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(20, 255)));
		qlen = 0;
		nops = $urandom_range(1, 5);
		for (int i = 0; i < nops; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 4 || sel == 9) cc = CIG_SOFT;
			else if (sel < 7)        cc = CIG_MATCH;
			else if (sel == 7)       cc = 4'($urandom_range(1, 8));
			else                     cc = 4'($urandom);
			sel = $urandom_range(0, 11);
			if (sel == 0)      ol = 28'($urandom);
			else if (sel == 1) ol = '0;
			else               ol = 28'($urandom_range(1, 14));
			cigar(cc, ol);
			if (ol < 64) qlen += ol;
		end
		if ($urandom_range(0, 9) != 0) begin
			qlen = (qlen > 24 ? 24 : qlen) + $urandom_range(0, 2);
			for (int i = 0; i < qlen; i++)
				qual(($urandom_range(0, 3) != 0) ? 8'($urandom_range(15, 60))
					: 8'($urandom));
		end
	endtask

	task automatic rand_phase(input int n_beats);
		int stop_at;
		stop_at = beats_sent + n_beats;
		while (beats_sent < stop_at) begin
			case ($urandom_range(0, 14))
			0: beat(2'($urandom), 16'($urandom), 31'($urandom), 16'($urandom),
				8'($urandom), 4'($urandom), 28'($urandom), 8'($urandom));
			1: flush_all();
			default: rand_read();
			endcase
		end
		flush_all();
	endtask

	initial begin
		beats_sent = 0;
		reads_sent = 0;
		idle_pct   = 18;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every cigar code, three clips in one read, quality extremes
		header(16'd0, 31'd1000, 16'h0, 8'd255);
		cigar(CIG_SOFT, 28'd12);
		for (int c = 0; c < 16; c++)
			if (c != CIG_SOFT) cigar(4'(c), 28'd3);
		cigar(CIG_SOFT, 28'd2);
		cigar(CIG_SOFT, 28'd5);
		qual(8'd0);
		qual(8'd255);
		header(16'd5, 31'd0, 16'h0004, 8'd60);
		cigar(CIG_SOFT, 28'd0);
		header(16'h7fff, 31'h7fff_ffff, 16'h0, 8'd0);
		flush_all();
		flush_all();
		settle();

		set_regs(32'h0000_0704, 32'd10, 32'd3, 32'd4, 32'd18, 32'd1);
		rand_phase(25);
		settle();

		idle_pct = 74;
		set_regs(32'hffff, 32'd255, 32'h7fff, 32'h0fff_ffff, 32'd255, 32'hffff_ffff);
		rand_phase(10);
		settle();
		set_regs(32'h0, 32'd0, 32'd2, 32'd2, 32'd10, 32'd2);
		rand_phase(20);
		settle();

		// fill past the table size on one reference; every stored site reports
		idle_pct = 0;
		set_regs(32'h0, 32'd0, 32'h7fff, 32'd1, 32'd0, 32'd0);
		for (int i = 0; i < 33; i++) begin
			header(16'd1, 31'(200 + 10 * i), 16'h0, 8'd0);
			cigar(CIG_SOFT, 28'd1);
			cigar(CIG_DEL, 28'd3);
			cigar(CIG_SOFT, 28'd1);
			qual(8'($urandom_range(1, 255)));
			qual(8'($urandom_range(1, 255)));
		end
		flush_all();
		settle();
		set_regs(32'h0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		rand_phase(15);
		settle();

		$display("%0d beats (%0d read headers) over six register settings, %0d sites reported",
			beats_sent, reads_sent, sites_seen);
		if (fail_count == 0)
			$display("** soft_clip_site_counter: PASSED **");
		else begin
			$display("%0d mismatches", fail_count);
			$display("** soft_clip_site_counter: FAILED **");
		end
		$finish;
	end

endmodule
